/* hdl/rcff_pkg.sv */
package rcff_pkg;

    // default width of the fade time base
    localparam int TIME_BITS_DEF = 24;

    // widest fade period that the register holds
    localparam int PERIOD_MAX_W = 24;

    localparam int LEVEL_W = 8;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // register indexes on the configuration port
    localparam logic [1:0] REG_TARGET_RED   = 2'd0;
    localparam logic [1:0] REG_TARGET_GREEN = 2'd1;
    localparam logic [1:0] REG_TARGET_BLUE  = 2'd2;
    localparam logic [1:0] REG_FADE_PERIOD  = 2'd3;

    // channel indexes in the sequencer
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CHK  = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_LVL  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

endpackage

/* hdl/rgb_color_flicker_fade.sv */
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_elapsed_ticks[15:0]
// result    out        o_valid / i_ready    o_red_level, o_green_level, o_blue_level,
//                                           o_fading_to_white
// config    in         psel/penable/pwrite  paddr[3:0], pwdata[31:0], prdata[31:0], pready
//
// an item snaps to the endpoint when the fade time reaches the period; otherwise one shared
// multiplier and one shared compare/subtract step run a multiply, divide and level pass
// (S_MUL, S_DIV, S_LVL) for each of the three channels, one quotient bit a cycle
// o_ready is high only while the sequencer is idle; a finished result sits in the
// output register and the next item is taken while it waits
// a stalled result holds the sequencer in its last state until the output register frees
// i_rst_n is synchronous, active low; it restores the register defaults (white target,
// period 1), clears the fade time and starts in the colour to white phase
module rgb_color_flicker_fade
    import rcff_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_elapsed_ticks,

    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red_level,
    output logic [7:0]  o_green_level,
    output logic [7:0]  o_blue_level,
    output logic        o_fading_to_white,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // period and fade time width: the period register never holds more than 24 bits
    localparam int PER_W = (TIME_BITS < PERIOD_MAX_W) ? TIME_BITS : PERIOD_MAX_W;
    // accumulated time plus one item's ticks, compared at full precision
    localparam int SUM_W = ((PER_W > 16) ? PER_W : 16) + 1;
    // product of a level span and the fade time
    localparam int DIV_W = PER_W + LEVEL_W;

    // configuration registers
    logic [LEVEL_W-1:0] r_target_red;
    logic [LEVEL_W-1:0] r_target_green;
    logic [LEVEL_W-1:0] r_target_blue;
    logic [PER_W-1:0]   r_period;

    // fade state
    logic [PER_W-1:0]   r_acc;
    logic               r_toward_colour;

    // sequencer
    t_state             r_state;
    logic [SUM_W-1:0]   r_sum;
    logic [1:0]         r_ch;
    logic [2:0]         r_bit;
    logic [DIV_W-1:0]   r_rem;
    logic [LEVEL_W-1:0] r_quo;
    logic [LEVEL_W-1:0] r_lvl [3];

    // combinational helpers
    logic               cfg_wr;
    logic [LEVEL_W-1:0] c_sel;
    logic [LEVEL_W-1:0] span;
    logic [DIV_W-1:0]   trial;
    logic [LEVEL_W:0]   up;
    logic [LEVEL_W-1:0] n_lvl;
    logic               out_free;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign o_ready  = (r_state == S_IDLE);
    assign out_free = !o_valid || i_ready;

    // register read back
    always_comb begin
        case (paddr[3:2])
            REG_TARGET_RED:   prdata = {24'd0, r_target_red};
            REG_TARGET_GREEN: prdata = {24'd0, r_target_green};
            REG_TARGET_BLUE:  prdata = {24'd0, r_target_blue};
            REG_FADE_PERIOD:  prdata = {{(32-PER_W){1'b0}}, r_period};
            default:          prdata = 32'd0;
        endcase
    end

    // target level of the channel being worked on
    always_comb begin
        case (r_ch)
            CH_RED:   c_sel = r_target_red;
            CH_GREEN: c_sel = r_target_green;
            CH_BLUE:  c_sel = r_target_blue;
            default:  c_sel = r_target_blue;
        endcase
    end

    // distance from the target to white, the full swing of this channel
    assign span  = LEVEL_MAX - c_sel;

    // period aligned to the quotient bit under test
    assign trial = DIV_W'(r_period) << r_bit;

    // toward colour rounds the step up, so the level is truncated toward zero
    assign up = {1'b0, r_quo} + {{LEVEL_W{1'b0}}, (r_rem != '0)};
    always_comb begin
        if (r_toward_colour) begin
            n_lvl = LEVEL_W'({1'b0, LEVEL_MAX} - up);
        end else begin
            n_lvl = c_sel + r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_red    <= LEVEL_MAX;
            r_target_green  <= LEVEL_MAX;
            r_target_blue   <= LEVEL_MAX;
            r_period        <= PER_W'(1);
            r_acc           <= '0;
            r_toward_colour <= 1'b0;
            r_state         <= S_IDLE;
            o_valid         <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_TARGET_RED:   r_target_red   <= pwdata[LEVEL_W-1:0];
                    REG_TARGET_GREEN: r_target_green <= pwdata[LEVEL_W-1:0];
                    REG_TARGET_BLUE:  r_target_blue  <= pwdata[LEVEL_W-1:0];
                    REG_FADE_PERIOD:  r_period       <= pwdata[PER_W-1:0];
                    default: ;
                endcase
            end

            // result taken downstream, unless a new one is loaded in its place
            if (o_valid && i_ready && (r_state != S_DONE)) begin
                o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_sum   <= SUM_W'(r_acc) + SUM_W'(i_elapsed_ticks);
                        r_state <= S_CHK;
                    end
                end

                S_CHK: begin
                    if (r_sum >= SUM_W'(r_period)) begin
                        // period reached: snap to the endpoint of this phase and flip
                        if (r_toward_colour) begin
                            r_lvl[CH_RED]   <= r_target_red;
                            r_lvl[CH_GREEN] <= r_target_green;
                            r_lvl[CH_BLUE]  <= r_target_blue;
                        end else begin
                            r_lvl[CH_RED]   <= LEVEL_MAX;
                            r_lvl[CH_GREEN] <= LEVEL_MAX;
                            r_lvl[CH_BLUE]  <= LEVEL_MAX;
                        end
                        r_acc           <= '0;
                        r_toward_colour <= !r_toward_colour;
                        r_state         <= S_DONE;
                    end else begin
                        // sum stays below the period, so it fits the time register
                        r_acc   <= r_sum[PER_W-1:0];
                        r_ch    <= CH_RED;
                        r_state <= S_MUL;
                    end
                end

                S_MUL: begin
                    // quotient of span * t / period stays below 256
                    r_rem   <= DIV_W'(span) * DIV_W'(r_acc);
                    r_quo   <= '0;
                    r_bit   <= 3'd7;
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (r_rem >= trial) begin
                        r_rem        <= r_rem - trial;
                        r_quo[r_bit] <= 1'b1;
                    end
                    if (r_bit == 3'd0) begin
                        r_state <= S_LVL;
                    end else begin
                        r_bit <= r_bit - 3'd1;
                    end
                end

                S_LVL: begin
                    r_lvl[r_ch] <= n_lvl;
                    if (r_ch == CH_BLUE) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= S_MUL;
                    end
                end

                S_DONE: begin
                    // wait for the output register to free up
                    if (out_free) begin
                        o_red_level       <= r_lvl[CH_RED];
                        o_green_level     <= r_lvl[CH_GREEN];
                        o_blue_level      <= r_lvl[CH_BLUE];
                        o_fading_to_white <= !r_toward_colour;
                        o_valid           <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/rcff_chk.sv */
module rcff_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_red_level,
    input logic [7:0] o_green_level,
    input logic [7:0] o_blue_level,
    input logic       o_fading_to_white
);

    // a result is never withdrawn before it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> ($stable(o_red_level) && $stable(o_green_level)
            && $stable(o_blue_level) && $stable(o_fading_to_white)))
        else $error("stalled result changed");

    // one item at a time: busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second item taken while busy");

    // a new result appears only as the sequencer returns to idle
    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_ready)
        else $error("result appeared while still busy");

endmodule

bind rgb_color_flicker_fade rcff_chk u_rcff_chk (.*);
